// ===== design/zbpp_pkg.sv =====
// ---------------------------------------------------------------------------
// zbpp_pkg - shared types and codes for the z-buffer point plotter
// Word layouts for both channels, command and status codes, cell reset values.
// ---------------------------------------------------------------------------
package zbpp_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_PLOT   = 2'd1;
    localparam logic [1:0] CMD_SMOOTH = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_HIDDEN = 2'd1;
    localparam logic [1:0] STATUS_OFF    = 2'd2;

    // cell contents after clear
    localparam logic [7:0]  SPACE_GLYPH = 8'd32;
    localparam logic [15:0] FAR_DEPTH   = 16'h8000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] depth;
        logic [7:0]         glyph;
        logic [5:0]         read_row;
        logic [5:0]         read_col;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] glyph_out;
    } t_out;

endpackage

// ===== design/zbpp_ram.sv =====
// ---------------------------------------------------------------------------
// zbpp_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module zbpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/zbuffer_point_plotter_core.sv =====
// ---------------------------------------------------------------------------
// zbuffer_point_plotter_core - z-buffered glyph plotter over a square grid
// Glyph and depth frame buffer with clear, plot, smooth and read commands.
// ---------------------------------------------------------------------------
// The block holds a GRID x GRID frame buffer (GRID = 2*HALF) of 8-bit glyphs
// and signed Q8.8 depths in two single-read, single-write RAMs. Every input
// word returns exactly one output word. For plot and read, the cycle that
// accepts the word issues the RAM read, the next cycle compares and writes
// back. Clear sweeps every RAM row, one per cycle, then hands its result to
// the output register. Smooth visits the (GRID-2)**2 interior cells in
// raster order; for each cell it makes four neighbor reads through the one
// read port, then writes back. After reset the same clearing sweep runs,
// with o_in_stall high and no output word. Only one command is in flight;
// o_in_stall is high while it runs, but a new word is taken while the
// previous result still waits in the output register.
// ---------------------------------------------------------------------------
module zbuffer_point_plotter_core #(
    parameter int HALF = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  zbpp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output zbpp_pkg::t_out o_out
);

    import zbpp_pkg::*;

    localparam int GRID  = 2 * HALF;
    localparam int RB    = $clog2(GRID);          // row / column index bits
    localparam int AW    = 2 * RB;                // RAM address = {row, col}
    localparam int DEPTH = 1 << AW;
    localparam int PW    = $clog2(HALF + 129) + 1; // signed projected index

    localparam logic signed [PW-1:0] HALF_S = PW'(HALF);
    localparam logic signed [PW-1:0] GRID_S = PW'(GRID);
    localparam logic [RB-1:0]        IDX_FIRST = RB'(1);
    localparam logic [RB-1:0]        IDX_LAST  = RB'(GRID - 2);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIN    = 3'd1;   // compare / write back
    localparam logic [2:0] ST_CLR    = 3'd2;   // clearing sweep
    localparam logic [2:0] ST_SMOOTH = 3'd3;   // neighbor sweep
    localparam logic [2:0] ST_OUT    = 3'd4;   // result waits for output reg

    // smoothing sub-steps: read above, below, left, right, then write
    localparam logic [2:0] SK_UP    = 3'd0;
    localparam logic [2:0] SK_DOWN  = 3'd1;
    localparam logic [2:0] SK_LEFT  = 3'd2;
    localparam logic [2:0] SK_RIGHT = 3'd3;
    localparam logic [2:0] SK_WRITE = 3'd4;

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    logic [2:0]    r_state,  n_state;
    logic          r_report, n_report;    // clear came from a command
    logic [AW-1:0] r_sweep,  n_sweep;
    logic [1:0]    r_cmd,    n_cmd;
    logic [AW-1:0] r_addr,   n_addr;
    logic          r_off,    n_off;
    logic [15:0]   r_depth,  n_depth;
    logic [7:0]    r_glyph,  n_glyph;
    logic [RB-1:0] r_sr,     n_sr;        // smoothing row
    logic [RB-1:0] r_sc,     n_sc;        // smoothing column
    logic [2:0]    r_sk,     n_sk;
    logic [7:0]    r_ga,     n_ga;        // neighbor above
    logic [7:0]    r_gb,     n_gb;        // neighbor below
    logic [7:0]    r_gl,     n_gl;        // neighbor left
    t_out          r_res,    n_res;
    logic          r_out_valid, n_out_valid;
    t_out          r_out,    n_out;

    // -----------------------------------------------------------------------
    // Handshake
    // -----------------------------------------------------------------------
    logic w_accept;
    logic w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // -----------------------------------------------------------------------
    // Cell projection on the incoming word: ceil(v/256) = (v+255) >>> 8
    // -----------------------------------------------------------------------
    logic signed [16:0]  w_sum_x, w_sum_y;
    logic signed [PW-1:0] w_row, w_col;
    logic          w_plot_off, w_read_off, w_acc_off;
    logic [AW-1:0] w_plot_addr, w_read_addr, w_acc_addr;

    assign w_sum_x = 17'(i_in.pos_x) + 17'sd255;
    assign w_sum_y = 17'(i_in.pos_y) + 17'sd255;
    assign w_row   = PW'($signed(w_sum_x[16:8])) + HALF_S;
    assign w_col   = PW'($signed(w_sum_y[16:8])) + HALF_S;

    assign w_plot_off = (w_row < 0) || (w_row >= GRID_S) ||
                        (w_col < 0) || (w_col >= GRID_S);
    assign w_plot_addr = {w_row[RB-1:0], w_col[RB-1:0]};

    assign w_read_off  = (int'(i_in.read_row) >= GRID) || (int'(i_in.read_col) >= GRID);
    assign w_read_addr = {RB'(i_in.read_row), RB'(i_in.read_col)};

    assign w_acc_off  = (i_in.cmd == CMD_READ) ? w_read_off  : w_plot_off;
    assign w_acc_addr = (i_in.cmd == CMD_READ) ? w_read_addr : w_plot_addr;

    // -----------------------------------------------------------------------
    // Smoothing neighbor address
    // -----------------------------------------------------------------------
    logic [RB-1:0] w_nb_row, w_nb_col;

    always_comb begin
        w_nb_row = r_sr;
        w_nb_col = r_sc;
        case (r_sk)
            SK_UP:    w_nb_row = r_sr - RB'(1);
            SK_DOWN:  w_nb_row = r_sr + RB'(1);
            SK_LEFT:  w_nb_col = r_sc - RB'(1);
            SK_RIGHT: w_nb_col = r_sc + RB'(1);
            default:  w_nb_row = r_sr;
        endcase
    end

    // -----------------------------------------------------------------------
    // RAMs
    // -----------------------------------------------------------------------
    logic          w_g_we, w_d_we, w_g_re, w_d_re;
    logic [AW-1:0] w_g_waddr, w_d_waddr, w_g_raddr;
    logic [7:0]    w_g_wdata, w_g_rdata;
    logic [15:0]   w_d_wdata, w_d_rdata;
    logic          w_smooth_rd;
    logic          w_plot_hit;
    logic          w_smooth_match;

    assign w_smooth_rd = (r_state == ST_SMOOTH) && (r_sk != SK_WRITE);
    assign w_g_re      = w_accept || w_smooth_rd;
    assign w_d_re      = w_accept;
    assign w_g_raddr   = (r_state == ST_SMOOTH) ? {w_nb_row, w_nb_col} : w_acc_addr;

    // strictly nearer wins
    assign w_plot_hit = (r_cmd == CMD_PLOT) && !r_off &&
                        ($signed(r_depth) > $signed(w_d_rdata));

    // right neighbor arrives on the read port in the write step
    assign w_smooth_match = (r_ga == r_gb) && (r_gb == r_gl) && (r_gl == w_g_rdata);

    always_comb begin
        w_g_we    = 1'b0;
        w_d_we    = 1'b0;
        w_g_waddr = r_addr;
        w_d_waddr = r_addr;
        w_g_wdata = r_glyph;
        w_d_wdata = r_depth;
        unique case (r_state)
            ST_CLR: begin
                w_g_we    = 1'b1;
                w_d_we    = 1'b1;
                w_g_waddr = r_sweep;
                w_d_waddr = r_sweep;
                w_g_wdata = SPACE_GLYPH;
                w_d_wdata = FAR_DEPTH;
            end
            ST_FIN: begin
                w_g_we = w_plot_hit;
                w_d_we = w_plot_hit;
            end
            ST_SMOOTH: begin
                w_g_we    = (r_sk == SK_WRITE) && w_smooth_match;
                w_g_waddr = {r_sr, r_sc};
                w_g_wdata = r_ga;
            end
            ST_IDLE, ST_OUT: begin
                w_g_we = 1'b0;
            end
            default: begin
                w_g_we = 1'b0;
            end
        endcase
    end

    zbpp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_g_we),
        .i_wr_addr (w_g_waddr),
        .i_wr_data (w_g_wdata),
        .i_rd_en   (w_g_re),
        .i_rd_addr (w_g_raddr),
        .o_rd_data (w_g_rdata)
    );

    zbpp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_depth_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_d_we),
        .i_wr_addr (w_d_waddr),
        .i_wr_data (w_d_wdata),
        .i_rd_en   (w_d_re),
        .i_rd_addr (w_acc_addr),
        .o_rd_data (w_d_rdata)
    );

    // -----------------------------------------------------------------------
    // Result of a plot or read, formed in the write-back cycle
    // -----------------------------------------------------------------------
    t_out w_fin_res;

    always_comb begin
        w_fin_res.glyph_out = '0;
        if (r_off) begin
            w_fin_res.status = STATUS_OFF;
        end else if (r_cmd == CMD_READ) begin
            w_fin_res.status    = STATUS_OK;
            w_fin_res.glyph_out = w_g_rdata;
        end else if (w_plot_hit) begin
            w_fin_res.status = STATUS_OK;
        end else begin
            w_fin_res.status = STATUS_HIDDEN;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_report    = r_report;
        n_sweep     = r_sweep;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_off       = r_off;
        n_depth     = r_depth;
        n_glyph     = r_glyph;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_sk        = r_sk;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_gl        = r_gl;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_in.cmd;
                    n_addr  = w_acc_addr;
                    n_off   = w_acc_off;
                    n_depth = i_in.depth;
                    n_glyph = i_in.glyph;
                    unique case (i_in.cmd)
                        CMD_CLEAR: begin
                            n_state  = ST_CLR;
                            n_sweep  = '0;
                            n_report = 1'b1;
                        end
                        CMD_SMOOTH: begin
                            n_state = ST_SMOOTH;
                            n_sr    = IDX_FIRST;
                            n_sc    = IDX_FIRST;
                            n_sk    = SK_UP;
                        end
                        CMD_PLOT, CMD_READ: begin
                            n_state = ST_FIN;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out       = w_fin_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_res   = w_fin_res;
                    n_state = ST_OUT;
                end
            end
            ST_CLR: begin
                n_sweep = r_sweep + AW'(1);
                if (&r_sweep) begin
                    n_res   = '0;
                    n_state = r_report ? ST_OUT : ST_IDLE;
                end
            end
            ST_SMOOTH: begin
                case (r_sk)
                    SK_DOWN:  n_ga = w_g_rdata;
                    SK_LEFT:  n_gb = w_g_rdata;
                    SK_RIGHT: n_gl = w_g_rdata;
                    default:  n_ga = r_ga;
                endcase
                if (r_sk == SK_WRITE) begin
                    n_sk = SK_UP;
                    if (r_sc == IDX_LAST) begin
                        n_sc = IDX_FIRST;
                        n_sr = r_sr + RB'(1);
                        if (r_sr == IDX_LAST) begin
                            n_res   = '0;
                            n_state = ST_OUT;
                        end
                    end else begin
                        n_sc = r_sc + RB'(1);
                    end
                end else begin
                    n_sk = r_sk + 3'd1;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state: reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_report    <= 1'b0;
            r_sweep     <= '0;
            r_sk        <= SK_UP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_report    <= n_report;
            r_sweep     <= n_sweep;
            r_sk        <= n_sk;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_off   <= n_off;
        r_depth <= n_depth;
        r_glyph <= n_glyph;
        r_sr    <= n_sr;
        r_sc    <= n_sc;
        r_ga    <= n_ga;
        r_gb    <= n_gb;
        r_gl    <= n_gl;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

// ===== design/zbpp_checker.sv =====
// ---------------------------------------------------------------------------
// zbpp_checker - port-level checks for the z-buffer point plotter
// Watches handshake and result words on the top level's ports.
// ---------------------------------------------------------------------------
module zbpp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_stall,
    input  logic           o_out_valid,
    input  logic           i_out_stall,
    input  zbpp_pkg::t_out o_out
);

    import zbpp_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // a glyph is carried only by a result with status OK
    a_glyph_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.glyph_out != 8'd0) |-> o_out.status == STATUS_OK)
        else $error("glyph on a non-read or failed result");

    // status code is one of the three defined
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == STATUS_OK) || (o_out.status == STATUS_HIDDEN) ||
                        (o_out.status == STATUS_OFF))
        else $error("undefined status code");

    // one command at a time: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while a command runs");

    // reset starts the clearing sweep with no result pending
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_stall && !o_out_valid)
        else $error("input open or result shown right after reset");

endmodule

bind zbuffer_point_plotter_core zbpp_checker u_zbpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
